FILE: hw/rtl/vsd_pkg.sv
// Shared commands, status codes and register constants of the vertex and segment table.
`timescale 1ns / 1ps
package vsd_pkg;

   localparam int TOL_W = 31;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_TOL_ADDR = 3'd0;

   typedef enum logic [1:0] {
      CMD_ADD_VERTEX  = 2'd0,
      CMD_ADD_SEGMENT = 2'd1,
      CMD_SET_Z       = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_MATCH   = 3'd1,
      ST_INVALID = 3'd2,
      ST_DUP     = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

endpackage

FILE: hw/rtl/vsd_vertex_cell.sv
// One vertex cell: holds one stored vertex and compares the passing query against it.
`timescale 1ns / 1ps
module vsd_vertex_cell import vsd_pkg::*; #(
   parameter int COORD_W = 32,
   parameter int IDX_W = 8,
   parameter int CNT_W = 9,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   count,
   input  logic [TOL_W-1:0]   tol,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_idx,
   input  logic [COORD_W-1:0] wr_x,
   input  logic [COORD_W-1:0] wr_y,
   input  logic               in_valid,
   input  logic               in_found,
   input  logic [IDX_W-1:0]   in_idx,
   input  logic [COORD_W-1:0] in_x,
   input  logic [COORD_W-1:0] in_y,
   output logic               out_valid,
   output logic               out_found,
   output logic [IDX_W-1:0]   out_idx,
   output logic [COORD_W-1:0] out_x,
   output logic [COORD_W-1:0] out_y
);

   localparam int DIFF_W = (COORD_W + 2 > 32) ? COORD_W + 2 : 32;

   logic [COORD_W-1:0] sx_ff, sy_ff;
   logic               valid_ff, found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COORD_W-1:0] qx_ff, qy_ff;
   logic signed [DIFF_W-1:0] dx, dy;
   logic [DIFF_W-1:0]  magx, magy;
   logic               live, hit;

   always_comb begin
      dx = DIFF_W'($signed(in_x)) - DIFF_W'($signed(sx_ff));
      dy = DIFF_W'($signed(in_y)) - DIFF_W'($signed(sy_ff));
      magx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      magy = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      live = CNT_W'(INDEX) < count;
      hit = live && (magx <= DIFF_W'(tol)) && (magy <= DIFF_W'(tol));
      found_in = in_found || (in_valid && hit);
      idx_in = in_found ? in_idx : IDX_W'(INDEX);
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
         sx_ff <= wr_x;
         sy_ff <= wr_y;
      end
      found_ff <= found_in;
      idx_ff <= idx_in;
      qx_ff <= in_x;
      qy_ff <= in_y;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_found = found_ff;
   assign out_idx = idx_ff;
   assign out_x = qx_ff;
   assign out_y = qy_ff;

endmodule

FILE: hw/rtl/vsd_segment_cell.sv
// One segment cell: holds one stored segment and checks the passing query in either order.
`timescale 1ns / 1ps
module vsd_segment_cell #(
   parameter int VIDX_W = 8,
   parameter int SIDX_W = 8,
   parameter int CNT_W = 9,
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  count,
   input  logic              wr_en,
   input  logic [SIDX_W-1:0] wr_idx,
   input  logic [VIDX_W-1:0] wr_a,
   input  logic [VIDX_W-1:0] wr_b,
   input  logic              in_valid,
   input  logic              in_found,
   input  logic [SIDX_W-1:0] in_idx,
   input  logic [VIDX_W-1:0] in_a,
   input  logic [VIDX_W-1:0] in_b,
   output logic              out_valid,
   output logic              out_found,
   output logic [SIDX_W-1:0] out_idx,
   output logic [VIDX_W-1:0] out_a,
   output logic [VIDX_W-1:0] out_b
);

   logic [VIDX_W-1:0] sf_ff, ss_ff, qa_ff, qb_ff;
   logic              valid_ff, found_ff, found_in, live, hit;
   logic [SIDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      live = CNT_W'(INDEX) < count;
      hit = live && (((sf_ff == in_a) && (ss_ff == in_b)) ||
                     ((sf_ff == in_b) && (ss_ff == in_a)));
      found_in = in_found || (in_valid && hit);
      idx_in = in_found ? in_idx : SIDX_W'(INDEX);
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == SIDX_W'(INDEX))) begin
         sf_ff <= wr_a;
         ss_ff <= wr_b;
      end
      found_ff <= found_in;
      idx_ff <= idx_in;
      qa_ff <= in_a;
      qb_ff <= in_b;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_found = found_ff;
   assign out_idx = idx_ff;
   assign out_a = qa_ff;
   assign out_b = qb_ff;

endmodule

FILE: hw/rtl/vertex_segment_dedup_table_core.sv
// Top level of the vertex and segment de-duplicating table.
`timescale 1ns / 1ps
// The block takes one command transaction at a time and answers each with one result
// transaction. An add-vertex command travels down a row of MAX_VERTICES vertex cells,
// each of which registers it; an add-segment command with valid indices likewise travels
// down the MAX_SEGMENTS segment cells. Set-z and rejected commands go straight to the
// response state. The match tolerance register lies at address 0.
module vertex_segment_dedup_table_core import vsd_pkg::*; #(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_SEGMENTS = 256,
   parameter int COORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic [COORD_BITS-1:0]   req_x_coord,
   input  logic [COORD_BITS-1:0]   req_y_coord,
   input  logic [COORD_BITS-1:0]   req_z_value,
   input  logic [7:0]              req_seg_start,
   input  logic [7:0]              req_seg_end,
   input  logic [7:0]              req_target_vertex,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_result_index,
   output logic [8:0]              rsp_vertex_total,
   output logic [8:0]              rsp_segment_total,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int SIDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
   localparam int SCNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int RC_W = (VCNT_W > 8) ? VCNT_W : 8;

   typedef enum logic [1:0] {IDLE, SCAN_V, SCAN_S, RESP} state_type;

   state_type         state_ff;
   logic [VCNT_W-1:0] vcount_ff;
   logic [SCNT_W-1:0] scount_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic [2:0]        status_ff;
   logic [7:0]        index_ff;

   logic v_valid [MAX_VERTICES+1];
   logic v_found [MAX_VERTICES+1];
   logic [VIDX_W-1:0] v_idx [MAX_VERTICES+1];
   logic [COORD_BITS-1:0] v_x [MAX_VERTICES+1];
   logic [COORD_BITS-1:0] v_y [MAX_VERTICES+1];
   logic s_valid [MAX_SEGMENTS+1];
   logic s_found [MAX_SEGMENTS+1];
   logic [SIDX_W-1:0] s_idx [MAX_SEGMENTS+1];
   logic [VIDX_W-1:0] s_a [MAX_SEGMENTS+1];
   logic [VIDX_W-1:0] s_b [MAX_SEGMENTS+1];

   logic req_fire, seg_ok, v_full, s_full, v_wr, s_wr;

   assign req_ready = (state_ff == IDLE);
   assign req_fire = req_valid && req_ready;
   assign pready = 1'b1;
   assign prdata = (paddr == REG_TOL_ADDR) ? 32'(tol_ff) : 32'd0;

   assign v_full = (vcount_ff == VCNT_W'(MAX_VERTICES));
   assign s_full = (scount_ff == SCNT_W'(MAX_SEGMENTS));
   assign seg_ok = (RC_W'(req_seg_start) < RC_W'(vcount_ff)) &&
                   (RC_W'(req_seg_end) < RC_W'(vcount_ff)) &&
                   (req_seg_start != req_seg_end);

   assign v_valid[0] = req_fire && (req_command == CMD_ADD_VERTEX);
   assign v_found[0] = 1'b0;
   assign v_idx[0] = '0;
   assign v_x[0] = req_x_coord;
   assign v_y[0] = req_y_coord;
   assign s_valid[0] = req_fire && (req_command == CMD_ADD_SEGMENT) && seg_ok;
   assign s_found[0] = 1'b0;
   assign s_idx[0] = '0;
   assign s_a[0] = VIDX_W'(req_seg_start);
   assign s_b[0] = VIDX_W'(req_seg_end);

   assign v_wr = (state_ff == SCAN_V) && v_valid[MAX_VERTICES] &&
                 !v_found[MAX_VERTICES] && !v_full;
   assign s_wr = (state_ff == SCAN_S) && s_valid[MAX_SEGMENTS] &&
                 !s_found[MAX_SEGMENTS] && !s_full;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_vcell
      vsd_vertex_cell #(
         .COORD_W(COORD_BITS), .IDX_W(VIDX_W), .CNT_W(VCNT_W), .INDEX(i)
      ) u_cell (
         .clock(clock), .reset(reset), .count(vcount_ff), .tol(tol_ff),
         .wr_en(v_wr), .wr_idx(vcount_ff[VIDX_W-1:0]),
         .wr_x(v_x[MAX_VERTICES]), .wr_y(v_y[MAX_VERTICES]),
         .in_valid(v_valid[i]), .in_found(v_found[i]), .in_idx(v_idx[i]),
         .in_x(v_x[i]), .in_y(v_y[i]),
         .out_valid(v_valid[i+1]), .out_found(v_found[i+1]), .out_idx(v_idx[i+1]),
         .out_x(v_x[i+1]), .out_y(v_y[i+1])
      );
   end

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_scell
      vsd_segment_cell #(
         .VIDX_W(VIDX_W), .SIDX_W(SIDX_W), .CNT_W(SCNT_W), .INDEX(i)
      ) u_cell (
         .clock(clock), .reset(reset), .count(scount_ff),
         .wr_en(s_wr), .wr_idx(scount_ff[SIDX_W-1:0]),
         .wr_a(s_a[MAX_SEGMENTS]), .wr_b(s_b[MAX_SEGMENTS]),
         .in_valid(s_valid[i]), .in_found(s_found[i]), .in_idx(s_idx[i]),
         .in_a(s_a[i]), .in_b(s_b[i]),
         .out_valid(s_valid[i+1]), .out_found(s_found[i+1]), .out_idx(s_idx[i+1]),
         .out_a(s_a[i+1]), .out_b(s_b[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         vcount_ff <= '0;
         scount_ff <= '0;
         tol_ff <= '0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr == REG_TOL_ADDR)) begin
            tol_ff <= pwdata[TOL_W-1:0];
         end
         unique case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  status_ff <= ST_INVALID;
                  index_ff <= 8'd0;
                  priority case (req_command)
                     CMD_ADD_VERTEX: state_ff <= SCAN_V;
                     CMD_ADD_SEGMENT: state_ff <= seg_ok ? SCAN_S : RESP;
                     CMD_SET_Z: begin
                        index_ff <= req_target_vertex;
                        if (RC_W'(req_target_vertex) < RC_W'(vcount_ff)) begin
                           status_ff <= ST_OK;
                        end
                        state_ff <= RESP;
                     end
                     default: state_ff <= RESP;
                  endcase
               end
            end
            SCAN_V: begin
               if (v_valid[MAX_VERTICES]) begin
                  state_ff <= RESP;
                  if (v_found[MAX_VERTICES]) begin
                     status_ff <= ST_MATCH;
                     index_ff <= 8'(v_idx[MAX_VERTICES]);
                  end else if (v_full) begin
                     status_ff <= ST_FULL;
                     index_ff <= 8'd0;
                  end else begin
                     status_ff <= ST_OK;
                     index_ff <= 8'(vcount_ff);
                     vcount_ff <= vcount_ff + 1'b1;
                  end
               end
            end
            SCAN_S: begin
               if (s_valid[MAX_SEGMENTS]) begin
                  state_ff <= RESP;
                  if (s_found[MAX_SEGMENTS]) begin
                     status_ff <= ST_DUP;
                     index_ff <= 8'(s_idx[MAX_SEGMENTS]);
                  end else if (s_full) begin
                     status_ff <= ST_FULL;
                     index_ff <= 8'd0;
                  end else begin
                     status_ff <= ST_OK;
                     index_ff <= 8'(scount_ff);
                     scount_ff <= scount_ff + 1'b1;
                  end
               end
            end
            RESP: begin
               if (rsp_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = (state_ff == RESP);
   assign rsp_status = status_ff;
   assign rsp_result_index = index_ff;
   assign rsp_vertex_total = 9'(vcount_ff);
   assign rsp_segment_total = 9'(scount_ff);

   a_vcount_step: assert property (@(posedge clock) disable iff (reset)
      (vcount_ff != $past(vcount_ff)) |-> (vcount_ff == $past(vcount_ff) + 1'b1))
      else $error("vertex count moved by other than one");
   a_vcount_max: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= VCNT_W'(MAX_VERTICES))
      else $error("vertex count beyond table depth");
   a_vscan_state: assert property (@(posedge clock) disable iff (reset)
      v_valid[MAX_VERTICES] |-> (state_ff == SCAN_V))
      else $error("vertex query left the chain outside a vertex scan");
   a_sscan_state: assert property (@(posedge clock) disable iff (reset)
      s_valid[MAX_SEGMENTS] |-> (state_ff == SCAN_S))
      else $error("segment query left the chain outside a segment scan");

endmodule
